// ----- rtl/nfpa_pkg.sv -----
// Shared types and constants for the next-fit page allocator.
// Holds request codes, controller states and bus field widths.
// No dependencies.
package nfpa_pkg;

	localparam int WORD_BITS = 32;
	localparam int BIT_W     = 5;
	localparam int IDX_W     = 10;
	localparam int REQ_W     = 2;
	localparam int NPG_W     = 11;
	localparam int TDATA_W   = 16;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW,
		ST_SCAN,
		ST_FIN
	} nfpa_state_t;

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] idx;
	} nfpa_res_t;

endpackage

// ----- rtl/nfpa_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the page bitmap store. No dependencies.
module nfpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/nfpa_ffs.sv -----
// Find-first-set unit: returns the lowest set bit of a bitmap word.
// Depends on nothing beyond its parameter.
module nfpa_ffs #(
	parameter int WIDTH = 32
) (
	input  logic [WIDTH-1:0]         vec,
	output logic                     hit,
	output logic [$clog2(WIDTH)-1:0] pos
);

	always_comb begin
		hit = |vec;
		pos = '0;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				pos = ($clog2(WIDTH))'(i);
			end
		end
	end

endmodule

// ----- rtl/next_fit_page_allocator.sv -----
// Top level of the next-fit page allocator: controller, scan pipeline and bitmap RAM.
// Depends on nfpa_pkg, nfpa_ram and nfpa_ffs.
//
// One request is handled at a time. Each RAM word holds 32 usable bits and 32 allocated bits.
// In-range free and mark requests read, modify and write one word. An allocate request reads
// one word per cycle from the scan pointer across the words the window spans (24 by default)
// and ends early at the first free usable page. With no pages present an allocation fails
// without a scan.
// After reset a clearing pass writes every RAM word, one per cycle, and no request is taken
// until it ends; configuration writes are taken at any time.
module next_fit_page_allocator #(
	parameter int TABLE_DEPTH = 1024,
	parameter int WINDOW_LO   = 256,
	parameter int WINDOW_HI   = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [nfpa_pkg::TDATA_W-1:0] s_tdata,  // [9:0] page_index, [10] usable_flag
	input  logic [nfpa_pkg::REQ_W-1:0]   s_tuser,  // [1:0] req_type
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [nfpa_pkg::TDATA_W-1:0] m_tdata,  // [9:0] result_index
	output logic                         m_tuser,  // [0] success
	input  logic                         cfg_we,
	input  logic [nfpa_pkg::NPG_W-1:0]   cfg_wdata
);

	localparam int WB     = nfpa_pkg::WORD_BITS;
	localparam int BW     = nfpa_pkg::BIT_W;
	localparam int NWORDS = (TABLE_DEPTH + WB - 1) / WB;
	localparam int AW     = NWORDS > 1 ? $clog2(NWORDS) : 1;
	localparam int PW     = AW + BW;
	localparam int HI_EFF = WINDOW_HI < TABLE_DEPTH ? WINDOW_HI : TABLE_DEPTH;
	localparam bit EMPTY  = WINDOW_LO >= HI_EFF;
	localparam int LO_V   = EMPTY ? 0 : WINDOW_LO;
	localparam int HI_V   = EMPTY ? 1 : HI_EFF;
	localparam int LO_W   = LO_V / WB;
	localparam int LO_B   = LO_V % WB;
	localparam int HL_W   = (HI_V - 1) / WB;
	localparam int HL_B   = (HI_V - 1) % WB;
	localparam int NREADS = HL_W - LO_W + 2;
	localparam int CW     = $clog2(NREADS + 1);

	localparam logic [PW:0]     LO_X    = (PW + 1)'(LO_V);
	localparam logic [PW:0]     HI_X    = (PW + 1)'(HI_V);
	localparam logic [PW-1:0]   LO_P    = PW'(LO_V);
	localparam logic [PW-1:0]   HL_P    = PW'(HI_V - 1);
	localparam logic [AW-1:0]   LO_WA   = AW'(LO_W);
	localparam logic [AW-1:0]   HL_WA   = AW'(HL_W);
	localparam logic [AW-1:0]   LAST_WA = AW'(NWORDS - 1);
	localparam logic [CW-1:0]   NRD_C   = CW'(NREADS);
	localparam logic [CW-1:0]   LASTK   = CW'(NREADS - 1);
	localparam logic [WB-1:0]   ONES    = {WB{1'b1}};
	localparam logic [WB-1:0]   LO_MASK = ONES << LO_B;
	localparam logic [WB-1:0]   HL_MASK = ONES >> (WB - 1 - HL_B);

	nfpa_pkg::nfpa_state_t state_q, state_d;

	logic [nfpa_pkg::REQ_W-1:0] req_q;
	logic [nfpa_pkg::IDX_W-1:0] idx_q;
	logic                       flag_q;
	logic [nfpa_pkg::NPG_W-1:0] num_pages_q;
	logic [PW-1:0]              next_scan_q;
	logic [AW-1:0]              clr_q;
	logic [BW-1:0]              start_bit_q;
	logic [AW-1:0]              iss_word_q;
	logic [CW-1:0]              iss_k_q;
	logic                       valid_s1;
	logic [AW-1:0]              word_s1;
	logic [CW-1:0]              k_s1;
	nfpa_pkg::nfpa_res_t        res_q, res_d, out_q;
	logic                       out_valid_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [2*WB-1:0]       ram_wdata, ram_rdata;

	logic                       s_accept, out_free, in_range, ns_in, iss_more;
	logic [nfpa_pkg::REQ_W-1:0] in_req;
	logic [nfpa_pkg::IDX_W-1:0] in_idx;
	logic [PW-1:0]              in_idx_p, idx_p, start_p, hit_page;
	logic [WB-1:0]              win_mask, k_mask, cand;
	logic                       hit;
	logic [BW-1:0]              hit_bit;
	logic                       res_load, ns_load, scan_start;

	assign in_req   = s_tuser;
	assign in_idx   = s_tdata[nfpa_pkg::IDX_W-1:0];
	assign in_idx_p = PW'(in_idx);
	assign idx_p    = PW'(idx_q);
	assign in_range = {22'd0, in_idx} < 32'(TABLE_DEPTH);
	assign s_tready = state_q == nfpa_pkg::ST_IDLE;
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign ns_in    = ({1'b0, next_scan_q} >= LO_X) && ({1'b0, next_scan_q} < HI_X);
	assign start_p  = ns_in ? next_scan_q : LO_P;
	assign iss_more = iss_k_q < NRD_C;

	always_comb begin
		win_mask = ONES;
		if (word_s1 == LO_WA) begin
			win_mask = win_mask & LO_MASK;
		end
		if (word_s1 == HL_WA) begin
			win_mask = win_mask & HL_MASK;
		end
		if (k_s1 == '0) begin
			k_mask = ONES << start_bit_q;
		end else if (k_s1 == LASTK) begin
			k_mask = ~(ONES << start_bit_q);
		end else begin
			k_mask = ONES;
		end
	end

	assign cand     = ram_rdata[WB-1:0] & ~ram_rdata[2*WB-1:WB] & win_mask & k_mask;
	assign hit_page = {word_s1, hit_bit};

	nfpa_ffs #(.WIDTH(WB)) u_ffs (
		.vec (cand),
		.hit (hit),
		.pos (hit_bit)
	);

	nfpa_ram #(.WIDTH(2 * WB), .DEPTH(NWORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = clr_q;
		ram_wdata  = '0;
		ram_raddr  = iss_word_q;
		res_load   = 1'b0;
		res_d      = '0;
		ns_load    = 1'b0;
		scan_start = 1'b0;
		unique case (state_q)
			nfpa_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == LAST_WA) begin
					state_d = nfpa_pkg::ST_IDLE;
				end
			end
			nfpa_pkg::ST_IDLE: begin
				ram_raddr = in_idx_p[PW-1:BW];
				if (s_accept) begin
					if (in_req == nfpa_pkg::REQ_ALLOC) begin
						if (num_pages_q == '0 || EMPTY) begin
							res_load = 1'b1;
							state_d  = nfpa_pkg::ST_FIN;
						end else begin
							scan_start = 1'b1;
							state_d    = nfpa_pkg::ST_SCAN;
						end
					end else if (in_range && (in_req == nfpa_pkg::REQ_FREE ||
							in_req == nfpa_pkg::REQ_MARK)) begin
						state_d = nfpa_pkg::ST_RMW;
					end else begin
						res_load  = 1'b1;
						res_d.idx = in_idx;
						state_d   = nfpa_pkg::ST_FIN;
					end
				end
			end
			nfpa_pkg::ST_RMW: begin
				ram_we    = 1'b1;
				ram_waddr = idx_p[PW-1:BW];
				ram_wdata = ram_rdata;
				if (req_q == nfpa_pkg::REQ_FREE) begin
					ram_wdata[WB + int'(idx_p[BW-1:0])] = 1'b0;
				end else begin
					ram_wdata[int'(idx_p[BW-1:0])] = flag_q;
				end
				res_load  = 1'b1;
				res_d.idx = idx_q;
				res_d.ok  = 1'b1;
				state_d   = nfpa_pkg::ST_FIN;
			end
			nfpa_pkg::ST_SCAN: begin
				if (valid_s1) begin
					if (hit) begin
						ram_we    = 1'b1;
						ram_waddr = word_s1;
						ram_wdata = ram_rdata;
						ram_wdata[WB + int'(hit_bit)] = 1'b1;
						ns_load   = 1'b1;
						res_load  = 1'b1;
						res_d.idx = nfpa_pkg::IDX_W'(hit_page);
						res_d.ok  = 1'b1;
						state_d   = nfpa_pkg::ST_FIN;
					end else if (k_s1 == LASTK) begin
						res_load = 1'b1;
						state_d  = nfpa_pkg::ST_FIN;
					end
				end
			end
			nfpa_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = nfpa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nfpa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nfpa_pkg::ST_CLEAR;
			clr_q       <= '0;
			num_pages_q <= '0;
			next_scan_q <= LO_P;
			valid_s1    <= 1'b0;
			iss_k_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == nfpa_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				num_pages_q <= cfg_wdata;
			end
			if (ns_load) begin
				next_scan_q <= (hit_page == HL_P) ? LO_P : hit_page + 1'b1;
			end
			valid_s1 <= state_q == nfpa_pkg::ST_SCAN && state_d == nfpa_pkg::ST_SCAN && iss_more;
			if (scan_start) begin
				iss_k_q <= '0;
			end else if (state_q == nfpa_pkg::ST_SCAN && iss_more) begin
				iss_k_q <= iss_k_q + 1'b1;
			end
			if (state_q == nfpa_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_q  <= in_req;
			idx_q  <= in_idx;
			flag_q <= s_tdata[nfpa_pkg::IDX_W];
		end
		if (scan_start) begin
			start_bit_q  <= start_p[BW-1:0];
			iss_word_q   <= start_p[PW-1:BW];
		end else if (state_q == nfpa_pkg::ST_SCAN && iss_more) begin
			iss_word_q <= (iss_word_q == HL_WA) ? LO_WA : iss_word_q + 1'b1;
		end
		if (state_q == nfpa_pkg::ST_SCAN) begin
			word_s1 <= iss_word_q;
			k_s1    <= iss_k_q;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == nfpa_pkg::ST_FIN && out_free) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = nfpa_pkg::TDATA_W'(out_q.idx);
	assign m_tuser  = out_q.ok;

endmodule

// ----- rtl/nfpa_chk.sv -----
// Port-level checker for the next-fit page allocator, bound to the top level.
// Depends on nfpa_pkg and next_fit_page_allocator.
module nfpa_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [nfpa_pkg::REQ_W-1:0]   s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [nfpa_pkg::TDATA_W-1:0] m_tdata,
	input logic                         m_tuser,
	input logic                         cfg_we,
	input logic [nfpa_pkg::NPG_W-1:0]   cfg_wdata
);

	logic [1:0] pend_q;
	logic       last_alloc_q;
	logic       cfg_zero_q;
	logic       in_beat, out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			last_alloc_q <= 1'b0;
			cfg_zero_q   <= 1'b1;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
			if (in_beat) begin
				last_alloc_q <= s_tuser == nfpa_pkg::REQ_ALLOC;
			end
			if (cfg_we) begin
				cfg_zero_q <= cfg_wdata == '0;
			end
		end
	end

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("request accepted while another was in work");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result beat without a pending request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two requests outstanding");

	a_zero_pages: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && pend_q == 2'd1 && last_alloc_q && cfg_zero_q |->
			!m_tuser && m_tdata[nfpa_pkg::IDX_W-1:0] == '0)
		else $error("allocation succeeded with zero pages present");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

endmodule

bind next_fit_page_allocator nfpa_chk u_nfpa_chk (.*);

// ----- bench/next_fit_page_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for next_fit_page_allocator: directed and random requests under random
// stalls on both streams, checked against a bitmap scoreboard. Depends on nfpa_pkg and the RTL.

class page_alloc_scoreboard #(int TABLE_DEPTH = 1024, int WINDOW_LO = 256, int WINDOW_HI = 1024);

	localparam int unsigned WIN_TOP = (WINDOW_HI > TABLE_DEPTH) ? TABLE_DEPTH : WINDOW_HI;

	bit taken[TABLE_DEPTH];
	bit usable[TABLE_DEPTH];
	int unsigned next_scan;
	logic [nfpa_pkg::NPG_W-1:0] num_pages;
	nfpa_pkg::nfpa_res_t pending[$];
	int unsigned errors, requests, results, grants, refusals;

	function new();
		next_scan = WINDOW_LO;
		num_pages = '0;
	endfunction

	function void set_num_pages(logic [nfpa_pkg::NPG_W-1:0] value);
		num_pages = value;
	endfunction

	function int unsigned outstanding();
		return pending.size();
	endfunction

	function void allocate(output logic [nfpa_pkg::IDX_W-1:0] page, output logic ok);
		int unsigned pos;
		page = '0;
		ok = 1'b0;
		if (num_pages == 0 || WINDOW_LO >= WIN_TOP)
			return;
		pos = (next_scan < WINDOW_LO || next_scan >= WIN_TOP) ? WINDOW_LO : next_scan;
		repeat (WIN_TOP - WINDOW_LO) begin
			if (usable[pos] && !taken[pos]) begin
				taken[pos] = 1'b1;
				next_scan = (pos + 1 >= WIN_TOP) ? WINDOW_LO : pos + 1;
				page = pos[nfpa_pkg::IDX_W-1:0];
				ok = 1'b1;
				return;
			end
			pos++;
			if (pos >= WIN_TOP)
				pos = WINDOW_LO;
		end
	endfunction

	function void note_request(logic [nfpa_pkg::REQ_W-1:0] req,
			logic [nfpa_pkg::IDX_W-1:0] idx, logic flag);
		nfpa_pkg::nfpa_res_t want;
		requests++;
		want.idx = idx;
		want.ok = 1'b0;
		if (req == nfpa_pkg::REQ_ALLOC) begin
			allocate(want.idx, want.ok);
			if (want.ok)
				grants++;
			else
				refusals++;
		end else if (idx < TABLE_DEPTH) begin
			if (req == nfpa_pkg::REQ_FREE) begin
				taken[idx] = 1'b0;
				want.ok = 1'b1;
			end else if (req == nfpa_pkg::REQ_MARK) begin
				usable[idx] = flag;
				want.ok = 1'b1;
			end
		end
		pending.push_back(want);
	endfunction

	function void check_result(logic [nfpa_pkg::IDX_W-1:0] idx, logic ok);
		nfpa_pkg::nfpa_res_t want;
		results++;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("Unexpected result beat: index %0d success %0b", idx, ok);
			return;
		end
		want = pending.pop_front();
		if (want.idx !== idx || want.ok !== ok) begin
			errors++;
			if (errors <= 10)
				$display("Result beat %0d: expected index %0d success %0b, got index %0d success %0b",
					results, want.idx, want.ok, idx, ok);
		end
	endfunction

endclass

module next_fit_page_allocator_tb;

	localparam int DEPTH = 1024;
	localparam int WIN_LO = 256;
	localparam int WIN_HI = 1024;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam logic [nfpa_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [nfpa_pkg::TDATA_W-1:0] s_tdata;
	logic [nfpa_pkg::REQ_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [nfpa_pkg::TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we;
	logic [nfpa_pkg::NPG_W-1:0] cfg_wdata;

	bit hold_request;
	bit no_idle;
	int unsigned mid_pages;
	page_alloc_scoreboard #(DEPTH, WIN_LO, WIN_HI) sb;

	next_fit_page_allocator #(
		.TABLE_DEPTH(DEPTH),
		.WINDOW_LO(WIN_LO),
		.WINDOW_HI(WIN_HI)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata[nfpa_pkg::IDX_W-1:0], s_tdata[nfpa_pkg::IDX_W]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[nfpa_pkg::IDX_W-1:0], m_tuser);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [nfpa_pkg::IDX_W-1:0] pick_page();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 10'(WIN_LO + $urandom_range(0, 15));
			4, 5: return 10'(WIN_HI - 16 + $urandom_range(0, 15));
			6: return 10'($urandom_range(0, WIN_LO - 1));
			default: return 10'($urandom_range(0, DEPTH - 1));
		endcase
	endfunction

	initial begin
		int unsigned stall_left, ready_left;
		m_tready = 1'b0;
		stall_left = 0;
		ready_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
				ready_left = 0;
			end
			if (stall_left == 0 && ready_left == 0) begin
				ready_left = $urandom_range(1, 24);
				stall_left = no_idle ? 0 : pick_gap();
			end
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				ready_left--;
			end
		end
	end

	task automatic send_request(input logic [nfpa_pkg::REQ_W-1:0] req,
			input logic [nfpa_pkg::IDX_W-1:0] idx, input logic flag);
		int unsigned gap;
		logic [nfpa_pkg::TDATA_W-1:0] beat_data;
		gap = no_idle ? 0 : pick_gap();
		beat_data = '0;
		beat_data[nfpa_pkg::IDX_W:0] = {flag, idx};
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= beat_data;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_num_pages(input logic [nfpa_pkg::NPG_W-1:0] value);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.outstanding() != 0);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		sb.set_num_pages(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int unsigned count, input bit pressure, input bit quiet);
		logic [nfpa_pkg::REQ_W-1:0] req;
		int unsigned roll;
		for (int i = 0; i < count; i++) begin
			if (pressure && i == 30)
				hold_request = 1'b1;
			if (pressure && i == count / 2) begin
				s_tvalid <= 1'b0;
				do @(negedge clk); while (sb.outstanding() != 0);
			end
			if (quiet && i == count / 2)
				no_idle = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 40)
				req = nfpa_pkg::REQ_ALLOC;
			else if (roll < 62)
				req = nfpa_pkg::REQ_FREE;
			else if (roll < 95)
				req = nfpa_pkg::REQ_MARK;
			else
				req = REQ_UNKNOWN;
			send_request(req, pick_page(), $urandom_range(0, 9) < 8);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_request = 1'b0;
		no_idle = 1'b0;
		mid_pages = $urandom_range(2, 1023);
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// With no pages present every allocation must fail.
		write_num_pages(11'd0);
		send_request(nfpa_pkg::REQ_MARK, 10'd256, 1'b1);
		send_request(nfpa_pkg::REQ_ALLOC, 10'd1023, 1'b1);
		send_request(nfpa_pkg::REQ_MARK, 10'd1023, 1'b1);
		send_request(nfpa_pkg::REQ_ALLOC, 10'd0, 1'b0);

		// Window edges, pointer wrap, full circle, pages outside the window, unknown type.
		write_num_pages(11'd1024);
		send_request(nfpa_pkg::REQ_ALLOC, 10'd0, 1'b0);
		send_request(nfpa_pkg::REQ_ALLOC, 10'd0, 1'b0);
		send_request(nfpa_pkg::REQ_ALLOC, 10'd0, 1'b0);
		send_request(nfpa_pkg::REQ_FREE, 10'd256, 1'b0);
		send_request(nfpa_pkg::REQ_ALLOC, 10'd1023, 1'b1);
		send_request(REQ_UNKNOWN, 10'd1023, 1'b1);
		send_request(REQ_UNKNOWN, 10'd0, 1'b0);
		send_request(nfpa_pkg::REQ_FREE, 10'd0, 1'b0);
		send_request(nfpa_pkg::REQ_MARK, 10'd0, 1'b1);
		send_request(nfpa_pkg::REQ_MARK, 10'd255, 1'b1);
		send_request(nfpa_pkg::REQ_MARK, 10'd1023, 1'b0);
		send_request(nfpa_pkg::REQ_FREE, 10'd1023, 1'b0);
		send_request(nfpa_pkg::REQ_ALLOC, 10'd0, 1'b0);
		send_request(nfpa_pkg::REQ_MARK, 10'd700, 1'b1);
		send_request(nfpa_pkg::REQ_ALLOC, 10'd0, 1'b0);
		send_request(nfpa_pkg::REQ_FREE, 10'd700, 1'b0);
		send_request(nfpa_pkg::REQ_ALLOC, 10'd0, 1'b0);

		random_phase(300, 1'b1, 1'b0);
		write_num_pages(11'd1);
		random_phase(220, 1'b0, 1'b1);
		write_num_pages(11'd2047);
		random_phase(220, 1'b0, 1'b0);
		write_num_pages(11'(mid_pages));
		random_phase(220, 1'b0, 1'b0);
		write_num_pages(11'd0);
		random_phase(150, 1'b0, 1'b0);
		write_num_pages(11'd1024);
		random_phase(200, 1'b0, 1'b1);

		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (40) @(posedge clk);
		sb.errors += sb.outstanding();

		$display("Checked %0d requests and %0d result beats: %0d pages granted, %0d refused.",
			sb.requests, sb.results, sb.grants, sb.refusals);
		$display("Page counts 0, 1, %0d, 1024 and 2047 were used; one receiver hold of %0d cycles.",
			mid_pages, HOLD_CYCLES);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Timeout with %0d results still expected.", sb.outstanding());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/nfpa_pkg.sv
rtl/nfpa_ram.sv
rtl/nfpa_ffs.sv
rtl/next_fit_page_allocator.sv
rtl/nfpa_chk.sv
bench/next_fit_page_allocator_tb.sv
